### rtl/cbms_pkg.sv
// ============================================================================
// cbms_pkg
// Shared types, codes and digit-roll helpers for the clock button mode
// sequencer.
// ============================================================================
package cbms_pkg;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int MODE_W   = 4;
    localparam int COUNT_W  = 12;
    localparam int SPM_W    = 8;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
    localparam logic [SPM_W-1:0]   SPM_RESET     = SPM_W'(20);
    localparam logic [COUNT_W-1:0] HOLD_RESET    = COUNT_W'(2000);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_PRESS_MIN = 1'b0,
        CFG_HOLD_COUNT      = 1'b1
    } cfg_idx_t;

    // Mode codes. Exit codes are transient and never reported.
    typedef enum logic [MODE_W-1:0] {
        MODE_TIME       = 4'd0,
        MODE_HOUR_TENS  = 4'd1,
        MODE_HOUR_UNITS = 4'd2,
        MODE_MIN_TENS   = 4'd3,
        MODE_MIN_UNITS  = 4'd4,
        MODE_SETUP_EXIT = 4'd5,
        MODE_SECONDS    = 4'd6,
        MODE_SEC_EXIT   = 4'd7,
        MODE_STOPWATCH  = 4'd8,
        MODE_SW_CLEAR   = 4'd9
    } mode_t;

    function automatic logic [HOUR_W-1:0] roll_hour_tens(input logic [HOUR_W-1:0] h);
        logic [HOUR_W-1:0] r;
        if (h < HOUR_W'(14))
            r = h + HOUR_W'(10);
        else if (h < HOUR_W'(20))
            r = HOUR_W'(20);
        else
            r = h - HOUR_W'(20);
        return r;
    endfunction

    function automatic logic [HOUR_W-1:0] roll_hour_units(input logic [HOUR_W-1:0] h);
        logic              nine;
        logic [HOUR_W-1:0] r;
        // A units digit of nine on a 5-bit value means 9, 19 or 29.
        nine = (h == HOUR_W'(9)) || (h == HOUR_W'(19)) || (h == HOUR_W'(29));
        if (!nine && h < HOUR_W'(23))
            r = h + HOUR_W'(1);
        else if (h >= HOUR_W'(23))
            r = h - HOUR_W'(3);
        else
            r = h - HOUR_W'(9);
        return r;
    endfunction

    function automatic logic [MINUTE_W-1:0] roll_minute_tens(input logic [MINUTE_W-1:0] m);
        logic [MINUTE_W-1:0] r;
        if (m < MINUTE_W'(50))
            r = m + MINUTE_W'(10);
        else
            r = m - MINUTE_W'(50);
        return r;
    endfunction

    function automatic logic [MINUTE_W-1:0] roll_minute_units(input logic [MINUTE_W-1:0] m);
        logic                nine;
        logic [MINUTE_W-1:0] r;
        nine = (m == MINUTE_W'(9))  || (m == MINUTE_W'(19)) || (m == MINUTE_W'(29)) ||
               (m == MINUTE_W'(39)) || (m == MINUTE_W'(49)) || (m == MINUTE_W'(59));
        if (!nine)
            r = m + MINUTE_W'(1);
        else
            r = m - MINUTE_W'(9);
        return r;
    endfunction

endpackage

### rtl/cbms_if.sv
// ============================================================================
// cbms_if
// Valid/ready channel interfaces for the button items and the results.
// ============================================================================
interface cbms_in_if;
    import cbms_pkg::*;

    logic                valid;
    logic                ready;
    logic                button_down;
    logic [HOUR_W-1:0]   current_hour;
    logic [MINUTE_W-1:0] current_minute;

    modport source (output valid, output button_down, output current_hour,
                    output current_minute, input ready);
    modport sink   (input valid, input button_down, input current_hour,
                    input current_minute, output ready);
endinterface

interface cbms_out_if;
    import cbms_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode_now;
    logic                tick_enable;
    logic                time_write;
    logic [HOUR_W-1:0]   new_hour;
    logic [MINUTE_W-1:0] new_minute;
    logic                clear_seconds;
    logic                clear_stopwatch;

    modport source (output valid, output mode_now, output tick_enable,
                    output time_write, output new_hour, output new_minute,
                    output clear_seconds, output clear_stopwatch, input ready);
    modport sink   (input valid, input mode_now, input tick_enable,
                    input time_write, input new_hour, input new_minute,
                    input clear_seconds, input clear_stopwatch, output ready);
endinterface

### rtl/clock_button_mode_sequencer_unit.sv
// ============================================================================
// clock_button_mode_sequencer_unit
// Button timing and mode sequencing for a clock: short presses, holds,
// digit setting of hour and minute, seconds and stopwatch display.
// ============================================================================
//
//  Channel  | Direction | Handshake     | Carries
//  ---------+-----------+---------------+-------------------------------------
//  item     | in        | valid/ready   | button_down, current_hour/minute
//  result   | out       | valid/ready   | mode, tick enable, time load, clears
//  cfg      | in        | write enable  | short_press_min, hold_count
//
//  One transaction is accepted per clock cycle while the result channel is not
//  stalled. A transaction is held in the input register and then lands in the
//  result register, from which its result is offered on the result channel.
//  The press counter and mode register update with each loaded result, which
//  sets the rate at one item per cycle.
//  Reset clears the pipeline, sets time display with ticking enabled, and
//  loads the configuration defaults. A stalled result holds both stages; the
//  item channel keeps accepting as long as the result register can drain.
//
module clock_button_mode_sequencer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    cbms_in_if.sink                     item,
    cbms_out_if.source                  result,
    input  logic                        cfg_write,
    input  logic [cbms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbms_pkg::CFG_W-1:0]  cfg_data
);
    import cbms_pkg::*;

    // Configuration registers.
    logic [SPM_W-1:0]    spm_reg;
    logic [COUNT_W-1:0]  hold_reg;

    // Sequencer state.
    mode_t               mode_reg, mode_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                tick_reg, tick_next;

    // Input stage.
    logic                s1_valid_reg;
    logic                s1_down_reg;
    logic [HOUR_W-1:0]   s1_hour_reg;
    logic [MINUTE_W-1:0] s1_min_reg;

    // Result stage.
    logic                out_valid_reg;
    mode_t               out_mode_reg;
    logic                out_tick_reg;
    logic                out_wr_reg, wr_next;
    logic [HOUR_W-1:0]   out_hour_reg, hour_next;
    logic [MINUTE_W-1:0] out_min_reg, min_next;
    logic                out_clr_sec_reg, clr_sec_next;
    logic                out_clr_sw_reg, clr_sw_next;

    // Handshake control.
    logic                advance;
    logic                load_out;
    logic                take_item;

    // Datapath intermediates.
    logic                count_inc;
    logic [COUNT_W-1:0]  count_step;
    logic                hold_hit;
    mode_t               mode_held;
    logic                short_press;

    // The result register frees up when it is empty or being taken; the input
    // register then moves forward, and so can accept a new transaction.
    assign advance    = !out_valid_reg || result.ready;
    assign load_out   = s1_valid_reg && advance;
    assign item.ready = !s1_valid_reg || advance;
    assign take_item  = item.valid && item.ready;

    // Press counter: counts while the button is down and saturates. A hold is
    // recognized only on the tick where the count steps onto hold_count, so
    // it fires once per press.
    always_comb
    begin
        count_inc   = s1_down_reg && (count_reg != COUNT_MAX);
        count_step  = count_inc ? count_reg + COUNT_W'(1) : count_reg;
        hold_hit    = count_inc && (count_step == hold_reg);
        mode_held   = hold_hit ? mode_t'(mode_reg + MODE_W'(1)) : mode_reg;
        // A release is a short press when the count lies strictly between
        // the two thresholds. The count is unchanged on a release tick.
        short_press = !s1_down_reg && (count_reg > {{(COUNT_W-SPM_W){1'b0}}, spm_reg})
                      && (count_reg < hold_reg);
        count_next  = s1_down_reg ? count_step : '0;
    end

    // Mode sequencing and digit rolls.
    always_comb
    begin
        mode_next    = mode_held;
        tick_next    = tick_reg;
        wr_next      = 1'b0;
        hour_next    = s1_hour_reg;
        min_next     = s1_min_reg;
        clr_sec_next = 1'b0;
        clr_sw_next  = 1'b0;
        case (mode_held)
            MODE_TIME:
            begin
                if (short_press)
                    mode_next = MODE_SECONDS;
            end
            MODE_HOUR_TENS:
            begin
                // Entering setup stops the timekeeper.
                tick_next = 1'b0;
                if (short_press)
                begin
                    hour_next = roll_hour_tens(s1_hour_reg);
                    wr_next   = 1'b1;
                end
            end
            MODE_HOUR_UNITS:
            begin
                if (short_press)
                begin
                    hour_next = roll_hour_units(s1_hour_reg);
                    wr_next   = 1'b1;
                end
            end
            MODE_MIN_TENS:
            begin
                if (short_press)
                begin
                    min_next = roll_minute_tens(s1_min_reg);
                    wr_next  = 1'b1;
                end
            end
            MODE_MIN_UNITS:
            begin
                if (short_press)
                begin
                    min_next = roll_minute_units(s1_min_reg);
                    wr_next  = 1'b1;
                end
            end
            MODE_SETUP_EXIT:
            begin
                // Holding past minute units leaves setup at once.
                clr_sec_next = 1'b1;
                tick_next    = 1'b1;
                mode_next    = MODE_TIME;
            end
            MODE_SECONDS:
            begin
                if (short_press)
                    mode_next = MODE_STOPWATCH;
            end
            MODE_STOPWATCH:
            begin
                if (short_press)
                    mode_next = MODE_TIME;
            end
            MODE_SW_CLEAR:
            begin
                // A hold in stopwatch display clears it and stays there.
                clr_sw_next = 1'b1;
                mode_next   = MODE_STOPWATCH;
            end
            default:
            begin
                // Holding past seconds display, or any unused code.
                mode_next = MODE_TIME;
            end
        endcase
    end

    // Control state, configuration and sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_TIME;
            count_reg     <= '0;
            tick_reg      <= 1'b1;
            spm_reg       <= SPM_RESET;
            hold_reg      <= HOLD_RESET;
        end
        else
        begin
            if (item.ready)
                s1_valid_reg <= item.valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
            if (load_out)
            begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                tick_reg  <= tick_next;
            end
            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SHORT_PRESS_MIN: spm_reg  <= cfg_data[SPM_W-1:0];
                    CFG_HOLD_COUNT:      hold_reg <= cfg_data[COUNT_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            s1_down_reg <= item.button_down;
            s1_hour_reg <= item.current_hour;
            s1_min_reg  <= item.current_minute;
        end
        if (load_out)
        begin
            out_mode_reg    <= mode_next;
            out_tick_reg    <= tick_next;
            out_wr_reg      <= wr_next;
            out_hour_reg    <= hour_next;
            out_min_reg     <= min_next;
            out_clr_sec_reg <= clr_sec_next;
            out_clr_sw_reg  <= clr_sw_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.mode_now        = out_mode_reg;
    assign result.tick_enable     = out_tick_reg;
    assign result.time_write      = out_wr_reg;
    assign result.new_hour        = out_hour_reg;
    assign result.new_minute      = out_min_reg;
    assign result.clear_seconds   = out_clr_sec_reg;
    assign result.clear_stopwatch = out_clr_sw_reg;

endmodule

### rtl/cbms_checker.sv
// ============================================================================
// cbms_checker
// Port-level checks on the result channel of the mode sequencer.
// ============================================================================
module cbms_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [cbms_pkg::MODE_W-1:0]   mode_now,
    input logic                          tick_enable,
    input logic                          time_write,
    input logic [cbms_pkg::HOUR_W-1:0]   new_hour,
    input logic [cbms_pkg::MINUTE_W-1:0] new_minute,
    input logic                          clear_seconds,
    input logic                          clear_stopwatch
);
    import cbms_pkg::*;

    logic in_setup;

    assign in_setup = (mode_now == MODE_HOUR_TENS) || (mode_now == MODE_HOUR_UNITS) ||
                      (mode_now == MODE_MIN_TENS)  || (mode_now == MODE_MIN_UNITS);

    // A stalled result keeps its whole payload.
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(mode_now) &&
        $stable(tick_enable) && $stable(time_write) && $stable(new_hour) &&
        $stable(new_minute) && $stable(clear_seconds) && $stable(clear_stopwatch))
        else $error("result payload changed while stalled");

    // Digit loads happen only in a set mode, and setup always stops the tick.
    a_write_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && time_write |-> in_setup)
        else $error("time_write outside digit setup");

    a_setup_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && in_setup |-> !tick_enable)
        else $error("tick enabled during digit setup");

    // Leaving setup returns to time display with ticking on.
    a_leave_setup: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && clear_seconds |-> (mode_now == MODE_TIME) && tick_enable)
        else $error("clear_seconds without return to time display");

    a_sw_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && clear_stopwatch |-> (mode_now == MODE_STOPWATCH))
        else $error("clear_stopwatch outside stopwatch display");

endmodule

bind clock_button_mode_sequencer_unit cbms_checker u_cbms_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .mode_now        (result.mode_now),
    .tick_enable     (result.tick_enable),
    .time_write      (result.time_write),
    .new_hour        (result.new_hour),
    .new_minute      (result.new_minute),
    .clear_seconds   (result.clear_seconds),
    .clear_stopwatch (result.clear_stopwatch)
);

### tb/clock_button_mode_sequencer_unit_test.sv
// ============================================================================
// clock_button_mode_sequencer_unit_test
// Self-checking bench for the clock button mode sequencer. It plays button
// tick streams into the item channel, predicts every result from its own
// model of the press counter and mode sequencer, and checks each result.
// ============================================================================
module clock_button_mode_sequencer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cbms_pkg::*;

    // The run is ended here if it has not finished on its own by then.
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    // Random phases and the number of ticks that each one queues.
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_TICKS   = 100;

    // One millisecond tick as it is offered to the block.
    typedef struct packed {
        logic                down;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } button_tick_t;

    // What the block reports for one tick.
    typedef struct packed {
        logic [MODE_W-1:0]   mode_now;
        logic                tick_enable;
        logic                time_write;
        logic [HOUR_W-1:0]   new_hour;
        logic [MINUTE_W-1:0] new_minute;
        logic                clear_seconds;
        logic                clear_stopwatch;
    } tick_outcome_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    cbms_in_if  item_if ();
    cbms_out_if result_if ();

    clock_button_mode_sequencer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if),
        .result    (result_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Ticks waiting to be driven, and outcomes predicted for accepted ticks
    // whose results have not come back yet.
    button_tick_t  pending_ticks[$];
    tick_outcome_t predicted_outcomes[$];

    // The bench's own copy of the sequencer state and its two registers.
    mode_t              sim_mode;
    logic [COUNT_W-1:0] sim_presses;
    logic               sim_ticking;
    logic [SPM_W-1:0]   short_min;
    logic [COUNT_W-1:0] hold_at;

    int unsigned  fail_count;
    int unsigned  cycle_count;
    int unsigned  queued_count;
    int unsigned  send_gap;
    int unsigned  stall_gap;
    bit           send_steady;
    bit           take_steady;
    button_tick_t next_tick;

    // Fixed register settings for the first random phases: an open short-press
    // window, a wider one, a hold count below the short-press minimum (no
    // short presses possible) and a hold count of zero (no holds possible).
    int unsigned phase_short_min[4] = '{0, 12, 30, 3};
    int unsigned phase_hold_at[4]   = '{21, 48, 25, 0};

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Advances the bench's sequencer state by one tick and returns the outcome
    // that the block must report for it. The press counter runs first, so a
    // hold changes the mode before the mode's own action on the same tick.
    function automatic tick_outcome_t predict_tick_outcome(input button_tick_t t);
        tick_outcome_t outcome;
        logic          short_press;
        int            h;
        int            m;

        h = int'(t.hour);
        m = int'(t.minute);
        outcome = '0;

        // The counter saturates, so a hold fires only on the tick that steps
        // onto the hold count, once per press.
        if (t.down && sim_presses != COUNT_MAX)
        begin
            sim_presses = sim_presses + 1'b1;
            if (sim_presses == hold_at)
                sim_mode = mode_t'(MODE_W'(sim_mode + 1'b1));
        end
        short_press = !t.down && sim_presses > short_min && sim_presses < hold_at;

        case (sim_mode)
            MODE_TIME:
                if (short_press)
                    sim_mode = MODE_SECONDS;
            MODE_HOUR_TENS:
            begin
                // Entering the setup stops the timekeeping tick.
                sim_ticking = 1'b0;
                if (short_press)
                begin
                    h = (h < 14) ? h + 10 : (h < 20) ? 20 : h - 20;
                    outcome.time_write = 1'b1;
                end
            end
            MODE_HOUR_UNITS:
                if (short_press)
                begin
                    if (h % 10 < 9 && h < 23)
                        h = h + 1;
                    else if (h >= 23)
                        h = h - 3;
                    else
                        h = h - 9;
                    outcome.time_write = 1'b1;
                end
            MODE_MIN_TENS:
                if (short_press)
                begin
                    m = (m < 50) ? m + 10 : m - 50;
                    outcome.time_write = 1'b1;
                end
            MODE_MIN_UNITS:
                if (short_press)
                begin
                    // A minute of 63 rolls to 64, which wraps to zero in six bits.
                    m = (m % 10 < 9) ? (m + 1) % 64 : m - 9;
                    outcome.time_write = 1'b1;
                end
            MODE_SETUP_EXIT:
            begin
                outcome.clear_seconds = 1'b1;
                sim_ticking = 1'b1;
                sim_mode = MODE_TIME;
            end
            MODE_SECONDS:
                if (short_press)
                    sim_mode = MODE_STOPWATCH;
            MODE_STOPWATCH:
                if (short_press)
                    sim_mode = MODE_TIME;
            MODE_SW_CLEAR:
            begin
                outcome.clear_stopwatch = 1'b1;
                sim_mode = MODE_STOPWATCH;
            end
            default:
                // A hold in seconds display and any unused code land here.
                sim_mode = MODE_TIME;
        endcase

        if (!t.down)
            sim_presses = '0;

        outcome.mode_now    = sim_mode;
        outcome.tick_enable = sim_ticking;
        outcome.new_hour    = HOUR_W'(h);
        outcome.new_minute  = MINUTE_W'(m);
        return outcome;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly legal clock values, now and then anything the field can hold.
    function automatic logic [HOUR_W-1:0] pick_hour();
        if ($urandom_range(0, 4) == 0)
            return HOUR_W'($urandom_range(0, 31));
        return HOUR_W'($urandom_range(0, 23));
    endfunction

    function automatic logic [MINUTE_W-1:0] pick_minute();
        if ($urandom_range(0, 4) == 0)
            return MINUTE_W'($urandom_range(0, 63));
        return MINUTE_W'($urandom_range(0, 59));
    endfunction

    // Idle span for either side: mostly none, sometimes short, rarely long.
    function automatic int unsigned pick_idle_span();
        int unsigned roll;

        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // Length of a press, chosen against the current registers so that most
    // presses are real short presses or holds and the rest are bounces, too
    // short to count, or no press at all.
    function automatic int unsigned pick_press_length();
        int unsigned roll;

        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 0;
        if (roll < 25)
            return $urandom_range(1, (short_min > 0) ? short_min : 1);
        if (roll < 75)
        begin
            if (hold_at > short_min + 1)
                return $urandom_range(short_min + 1, hold_at - 1);
            return $urandom_range(1, 40);
        end
        if (hold_at != 0)
            return hold_at + $urandom_range(0, 5);
        return $urandom_range(1, 60);
    endfunction

    // Queues a press: held ticks with the button down, then released ticks.
    // The first released tick carries the given time, since that is the tick
    // on which a short press adjusts a digit.
    task automatic queue_press(input int unsigned held, input int unsigned released,
                               input logic [HOUR_W-1:0] hour,
                               input logic [MINUTE_W-1:0] minute);
        button_tick_t t;

        for (int unsigned i = 0; i < held; i++)
        begin
            t = '{1'b1, pick_hour(), pick_minute()};
            pending_ticks.push_back(t);
        end
        for (int unsigned i = 0; i < released; i++)
        begin
            t = (i == 0) ? button_tick_t'{1'b0, hour, minute}
                         : button_tick_t'{1'b0, pick_hour(), pick_minute()};
            pending_ticks.push_back(t);
        end
        queued_count += held + released;
    endtask

    // Waits until every queued tick has been accepted and every predicted
    // outcome has been checked, then lets the two-stage pipeline settle.
    task automatic wait_idle();
        while (pending_ticks.size() != 0 || item_if.valid || predicted_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes both registers while the block is idle, and the bench's copy.
    task automatic apply_setting(input int unsigned spm, input int unsigned hold);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SHORT_PRESS_MIN;
        cfg_data  <= CFG_W'(spm);
        @(posedge clk);
        cfg_index <= CFG_HOLD_COUNT;
        cfg_data  <= CFG_W'(hold);
        @(posedge clk);
        cfg_write <= 1'b0;
        short_min = SPM_W'(spm);
        hold_at   = COUNT_W'(hold);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
            report_failure($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    // Compares the result on the channel with the oldest prediction.
    task automatic check_outcome();
        tick_outcome_t want;

        if (predicted_outcomes.size() == 0)
        begin
            report_failure($sformatf("result with no prediction waiting, mode_now %0d",
                                     result_if.mode_now));
        end
        else
        begin
            want = predicted_outcomes.pop_front();
            compare_field("mode_now", 8'(want.mode_now), 8'(result_if.mode_now));
            compare_field("tick_enable", 8'(want.tick_enable), 8'(result_if.tick_enable));
            compare_field("time_write", 8'(want.time_write), 8'(result_if.time_write));
            compare_field("new_hour", 8'(want.new_hour), 8'(result_if.new_hour));
            compare_field("new_minute", 8'(want.new_minute), 8'(result_if.new_minute));
            compare_field("clear_seconds", 8'(want.clear_seconds),
                          8'(result_if.clear_seconds));
            compare_field("clear_stopwatch", 8'(want.clear_stopwatch),
                          8'(result_if.clear_stopwatch));
        end
    endtask

    // ------------------------------------------------------------------------
    // Item driver
    // ------------------------------------------------------------------------

    // Every transaction accepted on the item channel is fed to the predictor
    // at the same edge. A new tick is put up only when the slot is free: no
    // tick is on the channel, or the one that is there was just taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_if.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (item_if.valid && item_if.ready)
                predicted_outcomes.push_back(predict_tick_outcome(button_tick_t'{
                    item_if.button_down, item_if.current_hour, item_if.current_minute}));

            if (!item_if.valid || item_if.ready)
            begin
                if (send_gap > 0)
                begin
                    item_if.valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_ticks.size() != 0)
                begin
                    next_tick = pending_ticks.pop_front();
                    item_if.valid          <= 1'b1;
                    item_if.button_down    <= next_tick.down;
                    item_if.current_hour   <= next_tick.hour;
                    item_if.current_minute <= next_tick.minute;
                    // Now and then switch between gapped traffic and a run
                    // of back-to-back transactions.
                    if ($urandom_range(0, 99) == 0)
                        send_steady = !send_steady;
                    send_gap = send_steady ? 0 : pick_idle_span();
                end
                else
                begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------

    // Checks each accepted result and stalls the result channel at random,
    // with stretches where ready stays high throughout.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stall_gap = 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
                check_outcome();

            if (stall_gap > 0)
            begin
                result_if.ready <= 1'b0;
                stall_gap--;
            end
            else
            begin
                result_if.ready <= 1'b1;
                if ($urandom_range(0, 99) == 0)
                    take_steady = !take_steady;
                stall_gap = take_steady ? 0 : pick_idle_span();
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial
    begin
        int unsigned half_mark;
        // All block inputs are known from time zero on.
        rst_n                  = 1'b0;
        cfg_write              = 1'b0;
        cfg_index              = CFG_SHORT_PRESS_MIN;
        cfg_data               = '0;
        item_if.valid          = 1'b0;
        item_if.button_down    = 1'b0;
        item_if.current_hour   = '0;
        item_if.current_minute = '0;
        result_if.ready        = 1'b0;

        // The bench's state starts where reset leaves the block.
        sim_mode     = MODE_TIME;
        sim_presses  = '0;
        sim_ticking  = 1'b1;
        short_min    = SPM_RESET;
        hold_at      = HOLD_RESET;
        fail_count   = 0;
        cycle_count  = 0;
        queued_count = 0;
        send_steady  = 1'b0;
        take_steady  = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset registers: a press that ends exactly at the minimum is not a
        // short press, one tick more is, and moves time display to seconds.
        queue_press(20, 1, 5'd12, 6'd30);
        queue_press(21, 1, 5'd12, 6'd30);
        wait_idle();

        // A tiny window makes every mode reachable in a few ticks: a count of
        // two is a short press and a count of four is a hold.
        apply_setting(1, 4);
        queue_press(1, 1, 5'd0, 6'd0);    // too short, seconds display stays
        queue_press(2, 1, 5'd0, 6'd0);    // seconds to stopwatch
        queue_press(5, 1, 5'd0, 6'd0);    // hold clears the stopwatch, keeps going
        queue_press(2, 1, 5'd0, 6'd0);    // stopwatch back to time display
        queue_press(4, 1, 5'd0, 6'd0);    // hold enters hour tens, tick stops
        queue_press(2, 1, 5'd13, 6'd0);   // hour tens below fourteen
        queue_press(2, 1, 5'd14, 6'd0);   // hour tens snaps to twenty
        queue_press(2, 1, 5'd31, 6'd0);   // hour tens out of range
        queue_press(4, 1, 5'd0, 6'd0);    // on to hour units
        queue_press(2, 1, 5'd23, 6'd0);   // top hour wraps back
        queue_press(2, 1, 5'd9, 6'd0);    // units digit of nine
        queue_press(2, 1, 5'd22, 6'd0);
        queue_press(2, 1, 5'd31, 6'd0);
        queue_press(4, 1, 5'd0, 6'd0);    // on to minute tens
        queue_press(2, 1, 5'd0, 6'd49);
        queue_press(2, 1, 5'd0, 6'd50);
        queue_press(2, 1, 5'd0, 6'd63);
        queue_press(4, 1, 5'd0, 6'd0);    // on to minute units
        queue_press(2, 1, 5'd0, 6'd59);
        queue_press(2, 1, 5'd0, 6'd63);   // wraps to zero in six bits
        queue_press(2, 1, 5'd0, 6'd8);
        queue_press(4, 1, 5'd0, 6'd0);    // leaves setup, seconds cleared
        queue_press(2, 1, 5'd0, 6'd0);    // time to seconds
        queue_press(4, 1, 5'd0, 6'd0);    // hold in seconds returns to time
        wait_idle();

        // Top short-press minimum. At a minimum of 255 a count of 256 is
        // needed; the last press runs on past the hold count in seconds display
        // and returns to time display while the button is still down.
        apply_setting(255, 260);
        queue_press(255, 1, pick_hour(), pick_minute());
        queue_press(256, 1, pick_hour(), pick_minute());
        queue_press(262, 2, pick_hour(), pick_minute());
        wait_idle();

        // Random phases: mostly real presses and holds with random time
        // values. Halfway through each phase the sender holds off until every
        // result is back, with no register change.
        for (int unsigned p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 4)
                apply_setting(phase_short_min[p], phase_hold_at[p]);
            else
                apply_setting($urandom_range(0, 15), $urandom_range(21, 60));
            queued_count = 0;
            half_mark = PHASE_TICKS / 2;
            while (queued_count < PHASE_TICKS)
            begin
                queue_press(pick_press_length(), $urandom_range(1, 4),
                            pick_hour(), pick_minute());
                if (queued_count >= half_mark && half_mark != 0)
                begin
                    wait_idle();
                    half_mark = 0;
                end
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
